>>> design/cprm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprm_pkg
// Shared widths, reset values, register codes and sequencer states for the
// crank pulse rpm meter.
// ----------------------------------------------------------------------------
package cprm_pkg;

    localparam int CYLINDERS_DEF = 4;

    localparam int PERIOD_W   = 16;
    localparam int RPM_W      = 16;
    localparam int DEV_W      = 17;
    localparam int K_W        = 24;
    localparam int DIV_W      = 24;
    localparam int CYL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [K_W-1:0]      RPM_CONSTANT_RST  = 24'd3750000;
    localparam logic [PERIOD_W-1:0] TIMEOUT_LIMIT_RST = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] MIN_PERIOD        = 16'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_RPM_CONSTANT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_PAIR_RD,
        ST_PAIR_ACC,
        ST_MEAN_GO,
        ST_RPM_GO,
        ST_RPM_WAIT,
        ST_FILT_GO,
        ST_FILT_WAIT,
        ST_DONE
    } seq_state_t;

endpackage

>>> design/cprm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cprm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/cprm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cprm_div
// Shared restoring divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module cprm_div #(
    parameter int W = cprm_pkg::DIV_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;
    logic             last_step;

    assign trial     = {rem_reg, quo_reg[W-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});
    assign last_step = (cnt_reg == CNT_W'(W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> design/crank_pulse_rpm_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crank_pulse_rpm_meter
// Period-measurement tachometer for flywheel mark pulses.
// ----------------------------------------------------------------------------
// Each word on the input runs through the sequencer from one accept to the
// next; in_stall is high in every state but idle. The update state writes
// the counter and ring, each period summed takes one RAM read plus one
// accumulate, the two cylinder pairs are read from the ring and summed, the
// mean comes from a reciprocal multiply, and two passes of the shared 24-bit
// restoring divider (rpm, filtered rpm) follow. The done state loads the
// output register; it holds while the previous result there is still
// stalled. The result waits in that register, so the next word is taken
// while it is still stalled.
// The ring of 2*CYLINDERS periods sits in a small RAM with one valid bit per
// entry; a stop clears the valid bits at once.
// ----------------------------------------------------------------------------
module crank_pulse_rpm_meter #(
    parameter int CYLINDERS = cprm_pkg::CYLINDERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic                              glitch,
    input  logic [cprm_pkg::CYL_W-1:0]        cylinder_select,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cprm_pkg::PERIOD_W-1:0]     raw_period,
    output logic [cprm_pkg::RPM_W-1:0]        engine_rpm,
    output logic [cprm_pkg::RPM_W-1:0]        filtered_rpm,
    output logic signed [cprm_pkg::DEV_W-1:0] cylinder_deviation,
    output logic                              stopped,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cprm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cprm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import cprm_pkg::*;

    localparam int RING_LEN = 2 * CYLINDERS;
    localparam int IW       = $clog2(RING_LEN);
    localparam int TW       = PERIOD_W + $clog2(CYLINDERS + 1);
    localparam int STEP_W   = ($clog2(CYLINDERS) > 2) ? $clog2(CYLINDERS) : 2;
    localparam int PAIR_W   = PERIOD_W + 1;
    localparam int DIFF_W   = PERIOD_W + 2;
    localparam int MEAN_SH  = TW + $clog2(CYLINDERS);
    localparam int MUL_W    = MEAN_SH + 1;
    localparam int PROD_W   = TW + MUL_W;
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((64'd1 << MEAN_SH) + 64'(CYLINDERS) - 64'd1) / 64'(CYLINDERS));
    localparam logic signed [DIFF_W-1:0] DEV_HI = 18'sd32000;
    localparam logic signed [DIFF_W-1:0] DEV_LO = -18'sd32000;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic                 func_reg;
    logic                 glitch_reg;
    logic [CYL_W-1:0]     cyl_reg;
    logic [K_W-1:0]       rpm_constant_reg;
    logic [PERIOD_W-1:0]  timeout_limit_reg;
    logic [PERIOD_W-1:0]  tick_count_reg;
    logic                 counting_reg;
    logic [PERIOD_W-1:0]  last_period_reg;
    logic [RING_LEN-1:0]  valid_reg;
    logic [IW-1:0]        widx_reg;
    logic [IW-1:0]        ridx_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [TW-1:0]        total_reg;
    logic [PAIR_W-1:0]    pair0_reg;
    logic [PAIR_W-1:0]    pairc_reg;
    logic [PERIOD_W-1:0]  mean_reg;
    logic [RPM_W-1:0]     rpm_reg;
    logic [RPM_W-1:0]     filt_reg;
    logic                 rd_valid_reg;
    logic                 out_valid_reg;
    logic [PERIOD_W-1:0]  raw_period_reg;
    logic [RPM_W-1:0]     engine_rpm_reg;
    logic [RPM_W-1:0]     filtered_rpm_reg;
    logic [DEV_W-1:0]     dev_reg;
    logic                 stopped_reg;

    logic                 accept;
    logic                 edge_ok;
    logic [PERIOD_W-1:0]  tick_inc;
    logic                 stop_hit;
    logic [IW-1:0]        widx_wrap;
    logic [IW-1:0]        ridx_prev;
    logic [IW-1:0]        cyl_base;
    logic [IW-1:0]        rd_addr;
    logic [PERIOD_W-1:0]  ram_rd_data;
    logic [PERIOD_W-1:0]  entry;
    logic                 ram_wr_en;
    logic                 sum_last;
    logic                 out_free;
    logic [PROD_W-1:0]    mean_prod;
    logic                 div_start;
    logic [DIV_W-1:0]     div_num;
    logic [DIV_W-1:0]     div_den;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;
    logic [RPM_W-1:0]     div_sat;
    logic                 cyl_in_range;
    logic [PERIOD_W-1:0]  avg0;
    logic [PERIOD_W-1:0]  avgc;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] diff_clamped;
    logic [DEV_W-1:0]     dev_value;

    assign accept    = in_valid && !in_stall;
    assign edge_ok   = func_reg && !glitch_reg;
    assign tick_inc  = tick_count_reg + 16'd1;
    assign stop_hit  = !func_reg && counting_reg && (tick_inc >= timeout_limit_reg);
    assign widx_wrap = (widx_reg == IW'(RING_LEN - 1)) ? '0 : widx_reg + 1'b1;
    assign ridx_prev = (ridx_reg == '0) ? IW'(RING_LEN - 1) : ridx_reg - 1'b1;
    assign cyl_base  = IW'({cyl_reg, 1'b0});
    assign ram_wr_en = (state_reg == ST_UPDATE) && edge_ok;
    assign entry     = rd_valid_reg ? ram_rd_data : '0;
    assign sum_last  = (step_reg == STEP_W'(CYLINDERS - 1));
    assign out_free  = !out_valid_reg || !out_stall;
    assign mean_prod = PROD_W'(total_reg) * PROD_W'(MEAN_MUL);
    assign div_sat   = (div_quo[DIV_W-1:RPM_W] != '0) ? '1 : div_quo[RPM_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_UPDATE;
            ST_UPDATE:    state_next = ST_SUM_RD;
            ST_SUM_RD:    state_next = ST_SUM_ACC;
            ST_SUM_ACC:   state_next = sum_last ? ST_PAIR_RD : ST_SUM_RD;
            ST_PAIR_RD:   state_next = ST_PAIR_ACC;
            ST_PAIR_ACC:  state_next = (step_reg == STEP_W'(3)) ? ST_MEAN_GO : ST_PAIR_RD;
            ST_MEAN_GO:   state_next = ST_RPM_GO;
            ST_RPM_GO:    state_next = ST_RPM_WAIT;
            ST_RPM_WAIT:  if (div_done) state_next = ST_FILT_GO;
            ST_FILT_GO:   state_next = ST_FILT_WAIT;
            ST_FILT_WAIT: if (div_done) state_next = ST_DONE;
            ST_DONE:      if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        div_start = 1'b0;
        div_num   = rpm_constant_reg;
        div_den   = DIV_W'(last_period_reg);
        rd_addr   = ridx_prev;
        case (state_reg)
            ST_RPM_GO:
            begin
                div_start = 1'b1;
            end
            ST_FILT_GO:
            begin
                div_start = 1'b1;
                div_den   = DIV_W'(mean_reg);
            end
            ST_PAIR_RD:
            begin
                case (step_reg[1:0])
                    2'd0:    rd_addr = '0;
                    2'd1:    rd_addr = IW'(1);
                    2'd2:    rd_addr = cyl_base;
                    default: rd_addr = cyl_base | IW'(1);
                endcase
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rpm_constant_reg  <= RPM_CONSTANT_RST;
            timeout_limit_reg <= TIMEOUT_LIMIT_RST;
            tick_count_reg    <= '0;
            counting_reg      <= 1'b1;
            last_period_reg   <= '0;
            valid_reg         <= '0;
            widx_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RPM_CONSTANT)
                begin
                    rpm_constant_reg <= cfg_data[K_W-1:0];
                end
                else if (cfg_index == CFG_TIMEOUT_LIMIT)
                begin
                    timeout_limit_reg <= cfg_data[PERIOD_W-1:0];
                end
            end

            if (state_reg == ST_UPDATE)
            begin
                if (!func_reg)
                begin
                    if (counting_reg)
                    begin
                        tick_count_reg <= tick_inc;
                    end
                    if (stop_hit)
                    begin
                        counting_reg    <= 1'b0;
                        last_period_reg <= '0;
                        valid_reg       <= '0;
                    end
                end
                else if (!glitch_reg)
                begin
                    last_period_reg     <= tick_count_reg;
                    valid_reg[widx_reg] <= 1'b1;
                    widx_reg            <= widx_wrap;
                    tick_count_reg      <= '0;
                    counting_reg        <= 1'b1;
                end
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cyl_in_range = ({1'b0, cyl_reg} < 4'(CYLINDERS));
    assign avg0         = pair0_reg[PAIR_W-1:1];
    assign avgc         = pairc_reg[PAIR_W-1:1];
    assign diff         = $signed({2'b00, avg0}) - $signed({2'b00, avgc});

    always_comb
    begin
        if (diff > DEV_HI)
        begin
            diff_clamped = DEV_HI;
        end
        else if (diff < DEV_LO)
        begin
            diff_clamped = DEV_LO;
        end
        else
        begin
            diff_clamped = diff;
        end

        if (cyl_reg == '0)
        begin
            dev_value = {1'b0, avg0};
        end
        else if (!cyl_in_range)
        begin
            dev_value = '0;
        end
        else
        begin
            dev_value = diff_clamped[DEV_W-1:0];
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_reg[rd_addr];

        if (accept)
        begin
            func_reg   <= func;
            glitch_reg <= glitch;
            cyl_reg    <= cylinder_select;
        end

        case (state_reg)
            ST_UPDATE:
            begin
                ridx_reg  <= edge_ok ? widx_wrap : widx_reg;
                step_reg  <= '0;
                total_reg <= '0;
                pair0_reg <= '0;
                pairc_reg <= '0;
            end
            ST_SUM_RD:
            begin
                ridx_reg <= ridx_prev;
            end
            ST_SUM_ACC:
            begin
                total_reg <= total_reg + TW'(entry);
                step_reg  <= sum_last ? '0 : step_reg + 1'b1;
            end
            ST_PAIR_ACC:
            begin
                if (!step_reg[1])
                begin
                    pair0_reg <= pair0_reg + PAIR_W'(entry);
                end
                else
                begin
                    pairc_reg <= pairc_reg + PAIR_W'(entry);
                end
                step_reg <= step_reg + 1'b1;
            end
            ST_MEAN_GO:
            begin
                mean_reg <= mean_prod[MEAN_SH +: PERIOD_W];
            end
            ST_RPM_WAIT:
            begin
                if (div_done)
                begin
                    rpm_reg <= (last_period_reg < MIN_PERIOD) ? '0 : div_sat;
                end
            end
            ST_FILT_WAIT:
            begin
                if (div_done)
                begin
                    filt_reg <= (mean_reg == '0) ? '0 : div_sat;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    raw_period_reg   <= last_period_reg;
                    engine_rpm_reg   <= rpm_reg;
                    filtered_rpm_reg <= filt_reg;
                    dev_reg          <= dev_value;
                    stopped_reg      <= !counting_reg;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
    end

    cprm_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (RING_LEN)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (widx_reg),
        .wr_data (tick_count_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    cprm_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign cfg_ready          = 1'b1;
    assign out_valid          = out_valid_reg;
    assign raw_period         = raw_period_reg;
    assign engine_rpm         = engine_rpm_reg;
    assign filtered_rpm       = filtered_rpm_reg;
    assign cylinder_deviation = $signed(dev_reg);
    assign stopped            = stopped_reg;

    a_stop_clears_period: assert property (@(posedge clk) disable iff (!rst_n)
        !counting_reg |-> (last_period_reg == '0))
        else $error("period not cleared while stopped");

    a_stop_clears_ring: assert property (@(posedge clk) disable iff (!rst_n)
        !counting_reg |-> (valid_reg == '0))
        else $error("ring entries valid while stopped");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside of done state");

endmodule
